// File: rtl/spi_master_frame_shifter_assert.svh
// ---------------------------------------------------------------------------
// SPI master frame shifter assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef SPI_MASTER_FRAME_SHIFTER_ASSERT_SVH
`define SPI_MASTER_FRAME_SHIFTER_ASSERT_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define SMFS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("smfs assertion failed");
// cond must never be true outside reset
`define SMFS_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("smfs forbidden condition seen");
`else
`define SMFS_ASSERT(lbl, clk, rstn, prop)
`define SMFS_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// File: rtl/smfs_pkg.sv
// ---------------------------------------------------------------------------
// smfs_pkg
// Types and constants of the SPI master frame shifter.
// ---------------------------------------------------------------------------
package smfs_pkg;

  localparam int unsigned MaxFrameBits = 64;
  localparam int unsigned WordBits     = 64;
  localparam int unsigned LenW         = 7;   // frame bits register width
  localparam int unsigned IdxW         = $clog2(WordBits);
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = LenW;
  localparam int unsigned FifoDepth    = 4;
  localparam int unsigned PtrW         = $clog2(FifoDepth);
  localparam int unsigned CntW         = $clog2(FifoDepth + 1);

  localparam logic [LenW-1:0] LenReset = LenW'(8);
  localparam logic [LenW-1:0] LenMax   = LenW'(MaxFrameBits);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_BITS     = 2'd0,
    CFG_BIT_ORDER      = 2'd1,
    CFG_CLK_EDGE       = 2'd2,
    CFG_CS_ACTIVE_HIGH = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic                command;
    logic [WordBits-1:0] tx_word;
    logic                miso_level;
  } in_beat_t;

  typedef struct packed {
    logic                cs_level;
    logic                clk_level;
    logic                mosi_level;
    logic [WordBits-1:0] rx_word;
    logic                frame_done;
  } out_beat_t;

endpackage

// File: rtl/spi_master_frame_shifter.sv
// ---------------------------------------------------------------------------
// spi_master_frame_shifter
// SPI master pin sequencer: shifts one frame of 1 to 64 bits per start beat.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i/in_ready_o/in_data_i): a start beat loads the
//    transmit word and asserts chip select; a tick beat shifts one bit.
//    Ticks outside a frame are dropped without a result.
//  - Output channel (out_valid_o/out_ready_i/out_data_o): pin levels per
//    step. The last tick of a frame yields two beats: the active clock beat,
//    then the release beat carrying rx_word with frame_done set.
//  - Config port (cfg_we_i/cfg_idx_i/cfg_data_i): write only while idle.
//  - Results are registered in the output queue, not passed through combinationally.
//  - Throughput: one input beat per cycle while the queue has room; frame-ending
//    ticks add one extra output beat, so the output side sets the sustained rate.
//  - Results go into a 4-entry output queue; input is taken only while at
//    least two entries are free, so a stalled receiver stops the input once
//    three or more results are queued.
//  - Reset: config returns to 8 bits, MSB first, idle-low clock, active-low
//    chip select; frame state and queue are cleared.
// ---------------------------------------------------------------------------
`include "spi_master_frame_shifter_assert.svh"

module spi_master_frame_shifter import smfs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input beats
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_beat_t            in_data_i,
  // output beats
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_beat_t           out_data_o
);

  // config registers
  logic [LenW-1:0] frame_len_q;
  logic            lsb_first_q;
  logic            clk_idle_q;
  logic            cs_on_q;

  // frame state
  logic [WordBits-1:0] tx_hold_q, tx_hold_d;
  logic [WordBits-1:0] rx_accum_q, rx_accum_d;
  logic [LenW-1:0]     bit_cnt_q, bit_cnt_d;
  logic                in_frame_q, in_frame_d;

  // output queue
  out_beat_t         fifo_q [FifoDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  logic            in_acc, out_pop;
  logic [1:0]      push_n;
  out_beat_t       res0, res1;
  logic [LenW-1:0] eff_len, cnt_inc;
  logic [LenW-1:0] msb_idx;
  logic [IdxW-1:0] bit_idx;
  logic            mosi, last_bit;
  logic [WordBits-1:0] rx_next;
  logic [PtrW-1:0] wr_ptr_nx;

  assign in_ready_o  = (count_q <= CntW'(FifoDepth - 2));
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_valid_o = (count_q != '0);
  assign out_pop     = out_valid_o & out_ready_i;
  assign out_data_o  = fifo_q[rd_ptr_q];

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_len_q <= LenReset;
      lsb_first_q <= 1'b0;
      clk_idle_q  <= 1'b0;
      cs_on_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_BITS:     frame_len_q <= cfg_data_i[LenW-1:0];
        CFG_BIT_ORDER:      lsb_first_q <= cfg_data_i[0];
        CFG_CLK_EDGE:       clk_idle_q  <= cfg_data_i[0];
        CFG_CS_ACTIVE_HIGH: cs_on_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // frame length clamped into 1..MaxFrameBits
  always_comb begin
    if (frame_len_q == '0) begin
      eff_len = LenW'(1);
    end else if (frame_len_q > LenMax) begin
      eff_len = LenMax;
    end else begin
      eff_len = frame_len_q;
    end
  end

  // bit position of this tick; in MSB-first order a shortened frame lands on bit 0
  assign msb_idx  = (bit_cnt_q < eff_len) ? (eff_len - LenW'(1) - bit_cnt_q) : '0;
  assign bit_idx  = lsb_first_q ? bit_cnt_q[IdxW-1:0] : msb_idx[IdxW-1:0];
  assign mosi     = tx_hold_q[bit_idx];
  assign rx_next  = rx_accum_q | (WordBits'(in_data_i.miso_level) << bit_idx);
  assign cnt_inc  = bit_cnt_q + LenW'(1);
  assign last_bit = (cnt_inc >= eff_len);

  // step: next frame state and the results of the accepted beat
  always_comb begin
    tx_hold_d  = tx_hold_q;
    rx_accum_d = rx_accum_q;
    bit_cnt_d  = bit_cnt_q;
    in_frame_d = in_frame_q;
    push_n     = 2'd0;
    res0       = '{cs_level: cs_on_q, clk_level: clk_idle_q, mosi_level: 1'b0,
                   rx_word: '0, frame_done: 1'b0};
    res1       = '{cs_level: ~cs_on_q, clk_level: clk_idle_q, mosi_level: mosi,
                   rx_word: rx_next, frame_done: 1'b1};
    if (in_acc) begin
      if (cmd_e'(in_data_i.command) == CMD_START) begin
        tx_hold_d  = in_data_i.tx_word;
        rx_accum_d = '0;
        bit_cnt_d  = '0;
        in_frame_d = 1'b1;
        push_n     = 2'd1;
      end else if (in_frame_q) begin
        res0.clk_level  = ~clk_idle_q;
        res0.mosi_level = mosi;
        rx_accum_d      = rx_next;
        if (last_bit) begin
          bit_cnt_d  = '0;
          in_frame_d = 1'b0;
          push_n     = 2'd2;
        end else begin
          bit_cnt_d  = cnt_inc;
          push_n     = 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_hold_q  <= '0;
      rx_accum_q <= '0;
      bit_cnt_q  <= '0;
      in_frame_q <= 1'b0;
    end else begin
      tx_hold_q  <= tx_hold_d;
      rx_accum_q <= rx_accum_d;
      bit_cnt_q  <= bit_cnt_d;
      in_frame_q <= in_frame_d;
    end
  end

  // output queue
  assign wr_ptr_nx = wr_ptr_q + PtrW'(1);

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (push_n == 2'd2) begin
      fifo_q[wr_ptr_nx] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
      if (out_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + CntW'(push_n) - CntW'(out_pop);
    end
  end

  // assertions
  `SMFS_ASSERT_NEVER(a_fifo_overflow, clk_i, rst_ni, count_q > CntW'(FifoDepth))
  `SMFS_ASSERT(a_done_ends_frame, clk_i, rst_ni, (push_n == 2'd2) |=> !in_frame_q)
  `SMFS_ASSERT(a_idle_tick_dropped, clk_i, rst_ni,
    (in_acc && in_data_i.command && !in_frame_q && !out_pop) |=> $stable(count_q))
  `SMFS_ASSERT(a_count_in_range, clk_i, rst_ni,
    in_frame_q |-> (bit_cnt_q < LenW'(MaxFrameBits)))

endmodule
